@@ hw/rtl/pose_keyframe_trigger_unit_macros.svh @@
// assertion macros shared by the pose keyframe trigger rtl
// depends on a clock named aclk and a synchronous active-low reset named aresetn
`ifndef POSE_KEYFRAME_TRIGGER_UNIT_MACROS_SVH
`define POSE_KEYFRAME_TRIGGER_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define PKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pkt_pkg.sv @@
// shared widths, codes and types for the pose keyframe trigger
// no dependencies
`default_nettype none

package pkt_pkg;

    localparam int PosW     = 32;
    localparam int AxisN    = 3;
    localparam int RotElemW = 16;
    localparam int RotN     = 9;
    localparam int RowW     = 3 * RotElemW;
    localparam int ThrW     = 31;
    localparam int LimW     = 31;
    localparam int ScanW    = 16;
    localparam int KfW      = 32;
    localparam int DistW    = PosW;
    localparam int ProdW    = 2 * RotElemW;
    localparam int SqW      = 2 * DistW;
    localparam int SumW     = SqW + 2;
    localparam int ThrSqW   = 2 * ThrW;
    localparam int TraceW   = ProdW + 3;

    localparam int RotBase  = AxisN * PosW;
    localparam int InDataW  = RotBase + RotN * RotElemW;
    localparam int OutBits  = 1 + KfW + ScanW;
    localparam int OutDataW = ((OutBits + 7) / 8) * 8;

    localparam int CfgAddrW = 4;
    localparam int CfgDataW = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] RegMinTrans  = 2'd0;
    localparam logic [1:0] RegRotEnable = 2'd1;
    localparam logic [1:0] RegTraceLim  = 2'd2;
    localparam logic [1:0] RegMaxScans  = 2'd3;

    // action codes
    localparam logic ActEvaluate = 1'b0;
    localparam logic ActCommit   = 1'b1;

    // 1 + 2cos(0) in Q2.28
    localparam logic signed [LimW-1:0] TraceLimReset = 31'sd805306368;

    localparam logic [KfW-1:0]   KfOne   = 32'd1;
    localparam logic [ScanW-1:0] ScanOne = 16'd1;

    typedef struct packed {
        logic [ThrW-1:0]          min_translation;
        logic                     rotation_enable;
        logic signed [LimW-1:0]   rotation_trace_limit;
        logic [ScanW-1:0]         scan_limit;
    } cfg_t;

    // front stage to evaluation stage
    typedef struct packed {
        logic                              commit;
        logic                              no_ref;
        logic                              scan_hit;
        logic                              axis_hit;
        logic [AxisN-1:0][DistW-1:0]       axis_mag;
        logic [RotN-1:0][ProdW-1:0]        prod;
        logic [KfW-1:0]                    kf_total;
        logic [ScanW-1:0]                  scans;
    } front_t;

endpackage

`default_nettype wire

@@ hw/rtl/pose_keyframe_trigger_unit.sv @@
// top level of the pose keyframe trigger: apb registers, front stage, evaluation stage
// depends on pkt_pkg, pkt_cfg, pkt_front and pkt_eval
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata pose, s_tuser action
//  m_        out        m_tvalid / m_tready    m_tdata decision and counters
//  apb       in/out     psel penable pready    paddr, pwdata, prdata
//
// one beat in per cycle while m_tready holds, four register stages from input beat to output beat
// the reference pose and both counters change as a beat leaves the input register,
// so the next beat always sees the state left by the one before it
// aresetn is synchronous; it clears valid bits, counters, the stored-pose flag and
// the registers (trace limit resets to 1 + 2cos(0))
// a stalled m_tready backs up stage by stage; s_tready drops only when all stages are full
`default_nettype none

module pose_keyframe_trigger_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input beat
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], rot_row0[143:96],
    // rot_row1[191:144], rot_row2[239:192]
    input  wire logic [pkt_pkg::InDataW-1:0]   s_tdata,
    // action[0]: 0 evaluate, 1 commit
    input  wire logic                          s_tuser,
    // result beat
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // make_keyframe[0], keyframe_total[32:1], scans_since[48:33], zero pad [55:49]
    output logic [pkt_pkg::OutDataW-1:0]       m_tdata,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pkt_pkg::CfgAddrW-1:0]  paddr,
    input  wire logic [pkt_pkg::CfgDataW-1:0]  pwdata,
    output logic      [pkt_pkg::CfgDataW-1:0]  prdata,
    output logic                               pready
);

    pkt_pkg::cfg_t   cfg;
    pkt_pkg::front_t fr;
    logic            fr_valid;
    logic            fr_ready;

    // threshold registers
    pkt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, reference pose, counters, differences and products
    pkt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr       (fr)
    );

    // squares, trace, compares and output register
    pkt_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .fr_valid (fr_valid),
        .fr_ready (fr_ready),
        .fr       (fr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ hw/rtl/pkt_cfg.sv @@
// apb register file for the pose keyframe trigger thresholds
// depends on pkt_pkg
`default_nettype none

module pkt_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pkt_pkg::CfgAddrW-1:0]  paddr,
    input  wire logic [pkt_pkg::CfgDataW-1:0]  pwdata,
    output logic      [pkt_pkg::CfgDataW-1:0]  prdata,
    output logic                               pready,
    output pkt_pkg::cfg_t                      cfg
);

    pkt_pkg::cfg_t cfg_reg;
    pkt_pkg::cfg_t cfg_next;
    logic [1:0]    idx;
    logic          wr;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                pkt_pkg::RegMinTrans:  cfg_next.min_translation = pwdata[pkt_pkg::ThrW-1:0];
                pkt_pkg::RegRotEnable: cfg_next.rotation_enable = pwdata[0];
                pkt_pkg::RegTraceLim:
                    cfg_next.rotation_trace_limit = $signed(pwdata[pkt_pkg::LimW-1:0]);
                pkt_pkg::RegMaxScans:  cfg_next.scan_limit = pwdata[pkt_pkg::ScanW-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_translation      <= '0;
            cfg_reg.rotation_enable      <= 1'b0;
            cfg_reg.rotation_trace_limit <= pkt_pkg::TraceLimReset;
            cfg_reg.scan_limit           <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            pkt_pkg::RegMinTrans:  prdata = {1'b0, cfg_reg.min_translation};
            pkt_pkg::RegRotEnable: prdata = {31'b0, cfg_reg.rotation_enable};
            pkt_pkg::RegTraceLim:
                prdata = {cfg_reg.rotation_trace_limit[pkt_pkg::LimW-1],
                          cfg_reg.rotation_trace_limit};
            pkt_pkg::RegMaxScans:  prdata = {16'b0, cfg_reg.scan_limit};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/pkt_front.sv @@
// input register, reference pose and counters, axis differences and rotation products
// depends on pkt_pkg and the assertion macro header
`default_nettype none

`include "pose_keyframe_trigger_unit_macros.svh"

module pkt_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pkt_pkg::cfg_t                 cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pkt_pkg::InDataW-1:0]   s_tdata,
    input  wire logic                          s_tuser,
    output logic                               fr_valid,
    input  wire logic                          fr_ready,
    output pkt_pkg::front_t                    fr
);

    localparam int PosW   = pkt_pkg::PosW;
    localparam int AxisN  = pkt_pkg::AxisN;
    localparam int RotW   = pkt_pkg::RotElemW;
    localparam int RotN   = pkt_pkg::RotN;
    localparam int ScanW  = pkt_pkg::ScanW;
    localparam int KfW    = pkt_pkg::KfW;
    localparam int ProdW  = pkt_pkg::ProdW;

    // input register
    logic                       in_valid_reg;
    logic                       in_action_reg;
    logic signed [PosW-1:0]     in_pos_reg [AxisN];
    logic signed [RotW-1:0]     in_rot_reg [RotN];

    // reference pose and counters
    logic                       have_ref_reg;
    logic signed [PosW-1:0]     ref_pos_reg [AxisN];
    logic signed [RotW-1:0]     ref_rot_reg [RotN];
    logic [ScanW-1:0]           scan_cnt_reg;
    logic [KfW-1:0]             kf_cnt_reg;

    // stage register toward evaluation
    logic                       fr_valid_reg;
    pkt_pkg::front_t            fr_reg;
    pkt_pkg::front_t            fr_next;

    logic                       take;
    logic                       adv;
    logic                       s2_ready;
    logic                       commit;
    logic [ScanW-1:0]           scan_inc;
    logic [ScanW-1:0]           scan_cnt_next;
    logic [KfW-1:0]             kf_cnt_next;
    logic signed [PosW:0]       diff [AxisN];
    logic [PosW:0]              mag [AxisN];
    logic signed [ProdW-1:0]    prod [RotN];

    assign s2_ready = !fr_valid_reg || fr_ready;
    assign s_tready = !in_valid_reg || s2_ready;
    assign take     = s_tvalid && s_tready;
    assign adv      = in_valid_reg && s2_ready;
    assign commit   = (in_action_reg == pkt_pkg::ActCommit);

    assign fr_valid = fr_valid_reg;
    assign fr       = fr_reg;

    // counters as they stand after this item
    always_comb begin
        scan_inc      = (scan_cnt_reg == {ScanW{1'b1}}) ? scan_cnt_reg
                                                        : scan_cnt_reg + pkt_pkg::ScanOne;
        scan_cnt_next = commit ? '0 : scan_inc;
        kf_cnt_next   = commit ? kf_cnt_reg + pkt_pkg::KfOne : kf_cnt_reg;
    end

    always_comb begin
        fr_next          = '0;
        fr_next.commit   = commit;
        fr_next.no_ref   = !have_ref_reg;
        fr_next.scan_hit = (cfg.scan_limit != '0) && (scan_inc >= cfg.scan_limit);
        fr_next.kf_total = kf_cnt_next;
        fr_next.scans    = scan_cnt_next;
        fr_next.axis_hit = 1'b0;
        for (int i = 0; i < AxisN; i++) begin
            diff[i] = in_pos_reg[i] - ref_pos_reg[i];
            mag[i]  = diff[i][PosW] ? -diff[i] : diff[i];
            fr_next.axis_mag[i] = mag[i][PosW-1:0];
            if (mag[i][PosW-1:0] >= {1'b0, cfg.min_translation}) begin
                fr_next.axis_hit = 1'b1;
            end
        end
        for (int k = 0; k < RotN; k++) begin
            prod[k] = in_rot_reg[k] * ref_rot_reg[k];
            fr_next.prod[k] = prod[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_action_reg <= s_tuser;
            for (int i = 0; i < AxisN; i++) begin
                in_pos_reg[i] <= $signed(s_tdata[i*PosW +: PosW]);
            end
            for (int k = 0; k < RotN; k++) begin
                in_rot_reg[k] <= $signed(s_tdata[pkt_pkg::RotBase + k*RotW +: RotW]);
            end
        end
    end

    // state moves when the item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_ref_reg <= 1'b0;
            scan_cnt_reg <= '0;
            kf_cnt_reg   <= '0;
        end else if (adv) begin
            scan_cnt_reg <= scan_cnt_next;
            kf_cnt_reg   <= kf_cnt_next;
            if (commit) begin
                have_ref_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && commit) begin
            for (int i = 0; i < AxisN; i++) begin
                ref_pos_reg[i] <= in_pos_reg[i];
            end
            for (int k = 0; k < RotN; k++) begin
                ref_rot_reg[k] <= in_rot_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else if (adv) begin
            fr_valid_reg <= 1'b1;
        end else if (fr_ready) begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fr_reg <= fr_next;
        end
    end

    `PKT_ASSERT_NEXT(a_commit_clears_scans, adv && commit, scan_cnt_reg == '0, "scan count not cleared by commit")
    `PKT_ASSERT_NEXT(a_commit_counts_keyframe, adv && commit, kf_cnt_reg == $past(kf_cnt_reg) + pkt_pkg::KfOne, "keyframe count not advanced by commit")
    `PKT_ASSERT_NEXT(a_reference_sticky, have_ref_reg, have_ref_reg, "stored pose flag dropped")

endmodule

`default_nettype wire

@@ hw/rtl/pkt_eval.sv @@
// squares, trace sum, threshold compares and the result register
// depends on pkt_pkg and the assertion macro header
`default_nettype none

`include "pose_keyframe_trigger_unit_macros.svh"

module pkt_eval (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pkt_pkg::cfg_t                 cfg,
    input  wire logic                          fr_valid,
    output logic                               fr_ready,
    input  wire pkt_pkg::front_t               fr,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pkt_pkg::OutDataW-1:0]       m_tdata
);

    localparam int AxisN  = pkt_pkg::AxisN;
    localparam int RotN   = pkt_pkg::RotN;
    localparam int SqW    = pkt_pkg::SqW;
    localparam int SumW   = pkt_pkg::SumW;
    localparam int ThrSqW = pkt_pkg::ThrSqW;
    localparam int TraceW = pkt_pkg::TraceW;
    localparam int ScanW  = pkt_pkg::ScanW;
    localparam int KfW    = pkt_pkg::KfW;
    localparam int PadW   = pkt_pkg::OutDataW - pkt_pkg::OutBits;

    typedef struct packed {
        logic               commit;
        logic               no_ref;
        logic               scan_hit;
        logic               axis_hit;
        logic [KfW-1:0]     kf_total;
        logic [ScanW-1:0]   scans;
    } flags_t;

    logic                       s3_valid_reg;
    flags_t                     s3_reg;
    logic [SqW-1:0]             sq_reg [AxisN];
    logic [SqW-1:0]             sq_next [AxisN];
    logic signed [TraceW-1:0]   trace_reg;
    logic signed [TraceW-1:0]   trace_next;
    logic [ThrSqW-1:0]          thr_sq_reg;
    logic [ThrSqW-1:0]          thr_sq_next;

    logic                       out_valid_reg;
    logic                       out_make_reg;
    logic [KfW-1:0]             out_total_reg;
    logic [ScanW-1:0]           out_scans_reg;

    logic                       out_ready;
    logic                       s3_adv;
    logic [SumW-1:0]            dist_sq;
    logic                       trans_hit;
    logic                       rot_hit;
    logic                       make_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign fr_ready  = !s3_valid_reg || out_ready;
    assign s3_adv    = s3_valid_reg && out_ready;

    // products toward squared distance and trace
    always_comb begin
        for (int i = 0; i < AxisN; i++) begin
            sq_next[i] = SqW'(fr.axis_mag[i]) * SqW'(fr.axis_mag[i]);
        end
        thr_sq_next = ThrSqW'(cfg.min_translation) * ThrSqW'(cfg.min_translation);
        trace_next = '0;
        for (int k = 0; k < RotN; k++) begin
            trace_next = trace_next + TraceW'($signed(fr.prod[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (fr_valid && fr_ready) begin
            s3_valid_reg <= 1'b1;
        end else if (out_ready) begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fr_valid && fr_ready) begin
            s3_reg.commit   <= fr.commit;
            s3_reg.no_ref   <= fr.no_ref;
            s3_reg.scan_hit <= fr.scan_hit;
            s3_reg.axis_hit <= fr.axis_hit;
            s3_reg.kf_total <= fr.kf_total;
            s3_reg.scans    <= fr.scans;
            sq_reg          <= sq_next;
            trace_reg       <= trace_next;
            thr_sq_reg      <= thr_sq_next;
        end
    end

    // threshold decisions
    always_comb begin
        dist_sq   = SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
        trans_hit = (cfg.min_translation != '0)
                    && (s3_reg.axis_hit || (dist_sq >= SumW'(thr_sq_reg)));
        rot_hit   = cfg.rotation_enable
                    && (trace_reg <= TraceW'(cfg.rotation_trace_limit));
        make_next = (s3_reg.commit == pkt_pkg::ActEvaluate)
                    && (s3_reg.no_ref || trans_hit || rot_hit || s3_reg.scan_hit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s3_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            out_make_reg  <= make_next;
            out_total_reg <= s3_reg.kf_total;
            out_scans_reg <= s3_reg.scans;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PadW{1'b0}}, out_scans_reg, out_total_reg, out_make_reg};

    `PKT_ASSERT_NEXT(a_commit_never_requests, s3_adv && s3_reg.commit, out_valid_reg && !out_make_reg, "commit produced a keyframe request")

endmodule

`default_nettype wire

@@ bench/keyframe_decision_checker.sv @@
// checker for the pose keyframe trigger: watches the pose, decision and register ports,
// predicts each decision beat and compares it field by field
// depends on pkt_pkg
`default_nettype none

module keyframe_decision_checker
    import pkt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [InDataW-1:0]    s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OutDataW-1:0]   m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CfgAddrW-1:0]   paddr,
    input  wire logic [CfgDataW-1:0]   pwdata,
    input  wire logic                  pready,
    output int                         mismatch_count,
    output int                         decisions_pending
);

    // three squares of magnitudes below 2^32 fit in 67 bits
    localparam int SqSumW = 67;

    typedef struct packed {
        logic              make;
        logic [KfW-1:0]    kf_total;
        logic [ScanW-1:0]  scans;
    } decision_t;

    decision_t decisions_due[$];
    decision_t want;
    decision_t got;

    // register copies
    logic [ThrW-1:0]         min_trans;
    logic                    rot_en;
    logic signed [LimW-1:0]  trace_lim;
    logic [ScanW-1:0]        scan_limit;

    // stored keyframe pose and counters
    logic                        have_ref;
    logic [PosW-1:0]             ref_pos [AxisN];
    logic signed [RotElemW-1:0]  ref_rot [RotN];
    logic [ScanW-1:0]            scan_cnt;
    logic [KfW-1:0]              kf_cnt;

    logic [PosW-1:0]             pos [AxisN];
    logic signed [RotElemW-1:0]  rot [RotN];
    logic [PosW:0]               diff;
    logic [PosW:0]               mag;
    logic [SqSumW-1:0]           dist_sq;
    logic [SqSumW-1:0]           thr_sq;
    longint                      trace;
    logic                        trans_hit;
    logic                        rot_hit;
    logic                        scan_hit;

    int errors = 0;
    assign mismatch_count = errors;

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            decisions_due.delete();
            min_trans  = '0;
            rot_en     = 1'b0;
            trace_lim  = TraceLimReset;
            scan_limit = '0;
            have_ref   = 1'b0;
            for (int i = 0; i < AxisN; i++) ref_pos[i] = '0;
            for (int k = 0; k < RotN; k++) ref_rot[k] = '0;
            scan_cnt = '0;
            kf_cnt   = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegMinTrans:  min_trans  = pwdata[ThrW-1:0];
                    RegRotEnable: rot_en     = pwdata[0];
                    RegTraceLim:  trace_lim  = pwdata[LimW-1:0];
                    RegMaxScans:  scan_limit = pwdata[ScanW-1:0];
                    default: ;
                endcase
            end

            // compare first: a result never belongs to a pose taken in the same cycle
            if (m_tvalid && m_tready) begin
                got = '{make: m_tdata[0], kf_total: m_tdata[KfW:1],
                        scans: m_tdata[KfW+ScanW:KfW+1]};
                if (decisions_due.size() == 0) begin
                    report_mismatch("decision beat with nothing due", 0, m_tdata);
                end else begin
                    want = decisions_due.pop_front();
                    if (got.make != want.make)
                        report_mismatch("make_keyframe", want.make, got.make);
                    if (got.kf_total != want.kf_total)
                        report_mismatch("keyframe_total", want.kf_total, got.kf_total);
                    if (got.scans != want.scans)
                        report_mismatch("scans_since", want.scans, got.scans);
                end
            end

            if (s_tvalid && s_tready) begin
                for (int i = 0; i < AxisN; i++) pos[i] = s_tdata[i*PosW +: PosW];
                for (int k = 0; k < RotN; k++) rot[k] = s_tdata[RotBase + k*RotElemW +: RotElemW];
                want.make = 1'b0;
                if (s_tuser == ActCommit) begin
                    for (int i = 0; i < AxisN; i++) ref_pos[i] = pos[i];
                    for (int k = 0; k < RotN; k++) ref_rot[k] = rot[k];
                    have_ref = 1'b1;
                    scan_cnt = '0;
                    kf_cnt   = kf_cnt + KfOne;
                end else begin
                    if (scan_cnt != '1)
                        scan_cnt = scan_cnt + ScanOne;
                    if (!have_ref) begin
                        want.make = 1'b1;
                    end else begin
                        // exact squared distance, 33-bit axis differences
                        dist_sq = '0;
                        for (int i = 0; i < AxisN; i++) begin
                            diff = {pos[i][PosW-1], pos[i]} - {ref_pos[i][PosW-1], ref_pos[i]};
                            mag  = diff[PosW] ? -diff : diff;
                            dist_sq = dist_sq + SqSumW'(mag) * SqSumW'(mag);
                        end
                        thr_sq    = SqSumW'(min_trans) * SqSumW'(min_trans);
                        trans_hit = (min_trans != '0) && (dist_sq >= thr_sq);
                        // trace of R * Rref^T is the elementwise product sum
                        trace = 0;
                        for (int k = 0; k < RotN; k++)
                            trace = trace + longint'(rot[k]) * longint'(ref_rot[k]);
                        rot_hit   = rot_en && (trace <= longint'(trace_lim));
                        scan_hit  = (scan_limit != '0) && (scan_cnt >= scan_limit);
                        want.make = trans_hit | rot_hit | scan_hit;
                    end
                end
                want.kf_total = kf_cnt;
                want.scans    = scan_cnt;
                decisions_due.push_back(want);
            end
        end
        decisions_pending = decisions_due.size();
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// top of the pose keyframe trigger bench: clock, reset, pose and register stimulus, verdict
// depends on pkt_pkg, pose_keyframe_trigger_unit and keyframe_decision_checker
`default_nettype none

module tb;
    import pkt_pkg::*;

    localparam int RotBits     = RotN * RotElemW;
    localparam int StallLimit  = 2000;    // cycles with no beat on any port
    localparam int DrainCycles = 16;      // four pipeline stages plus margin
    localparam int PhaseItems  = 280;
    localparam int ScanRun     = 100;     // evaluates that run past the scan limit

    // Q1.14 unit and its negative
    localparam logic [RotElemW-1:0] QOne    = 16'sd16384;
    localparam logic [RotElemW-1:0] QNegOne = -16'sd16384;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [InDataW-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OutDataW-1:0]    m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CfgAddrW-1:0]    paddr;
    logic [CfgDataW-1:0]    pwdata;
    logic [CfgDataW-1:0]    prdata;
    logic                   pready;

    int mismatch_count;
    int decisions_pending;

    // idle odds in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // last committed position, used to aim random poses near the keyframe
    logic [PosW-1:0] anchor [AxisN] = '{default: '0};

    int stall_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pose_keyframe_trigger_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    keyframe_decision_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .mismatch_count    (mismatch_count),
        .decisions_pending (decisions_pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: any beat on either stream or a register access restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("pose_keyframe_trigger_unit test failed");
                $finish;
            end
        end
    end

    // pose beat layout: x, y, z, then the nine rotation elements row by row
    function automatic logic [InDataW-1:0] pose_beat(input logic [PosW-1:0] x,
                                                     input logic [PosW-1:0] y,
                                                     input logic [PosW-1:0] z,
                                                     input logic [RotBits-1:0] rot);
        return {rot, z, y, x};
    endfunction

    // a few exact turns: identity, quarter about z, half about x, quarter about y
    function automatic logic [RotBits-1:0] turn_matrix(input int sel);
        logic [RotBits-1:0] m;
        m = '0;
        case (sel)
            0: begin
                m[0*RotElemW +: RotElemW] = QOne;
                m[4*RotElemW +: RotElemW] = QOne;
                m[8*RotElemW +: RotElemW] = QOne;
            end
            1: begin
                m[1*RotElemW +: RotElemW] = QNegOne;
                m[3*RotElemW +: RotElemW] = QOne;
                m[8*RotElemW +: RotElemW] = QOne;
            end
            2: begin
                m[0*RotElemW +: RotElemW] = QOne;
                m[4*RotElemW +: RotElemW] = QNegOne;
                m[8*RotElemW +: RotElemW] = QNegOne;
            end
            default: begin
                m[2*RotElemW +: RotElemW] = QOne;
                m[4*RotElemW +: RotElemW] = QOne;
                m[6*RotElemW +: RotElemW] = QNegOne;
            end
        endcase
        return m;
    endfunction

    // one register write: setup cycle then access cycle
    task automatic apb_write(input logic [1:0] idx, input logic [CfgDataW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic configure(input logic [ThrW-1:0] min_trans, input logic rot_en,
                             input logic signed [LimW-1:0] trace_lim,
                             input logic [ScanW-1:0] scan_limit);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (decisions_pending != 0)
            @(negedge aclk);
        apb_write(RegMinTrans, {1'b0, min_trans});
        apb_write(RegRotEnable, {31'b0, rot_en});
        apb_write(RegTraceLim, {trace_lim[LimW-1], trace_lim});
        apb_write(RegMaxScans, {16'b0, scan_limit});
    endtask

    // present one pose beat, with optional idle cycles ahead of it, and hold until taken
    task automatic send_pose(input logic act, input logic [InDataW-1:0] beat);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        if (act == ActCommit)
            for (int i = 0; i < AxisN; i++) anchor[i] = beat[i*PosW +: PosW];
    endtask

    // random pose: mostly near the last keyframe, with clean turns plus noise,
    // the rest anywhere with arbitrary rotation bits
    task automatic send_random_pose(input bit evaluate_only);
        logic               act;
        logic [PosW-1:0]    p [AxisN];
        logic [RotBits-1:0] rot;
        int                 spread;
        act = (!evaluate_only && $urandom_range(7) == 0) ? ActCommit : ActEvaluate;
        spread = 1 << (4 * $urandom_range(6));
        for (int i = 0; i < AxisN; i++) begin
            if ($urandom_range(3) == 0)
                p[i] = $urandom();
            else
                p[i] = anchor[i] + 32'($urandom_range(2 * spread)) - 32'(spread);
        end
        if ($urandom_range(3) == 0) begin
            for (int k = 0; k < RotN; k++) rot[k*RotElemW +: RotElemW] = 16'($urandom());
        end else begin
            rot = turn_matrix($urandom_range(3));
            for (int k = 0; k < RotN; k++)
                rot[k*RotElemW +: RotElemW] = rot[k*RotElemW +: RotElemW]
                                              + 16'($urandom_range(128)) - 16'd64;
        end
        send_pose(act, pose_beat(p[0], p[1], p[2], rot));
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ActEvaluate;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, registers at reset values (all tests off) ----
        // first evaluation with nothing stored always asks for a keyframe
        send_pose(ActEvaluate, pose_beat('0, '0, '0, '0));
        send_pose(ActEvaluate, pose_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         {RotN{16'h7FFF}}));
        send_pose(ActCommit, pose_beat('0, '0, '0, turn_matrix(0)));
        send_pose(ActEvaluate, pose_beat('0, '0, '0, turn_matrix(0)));

        // rotation on with limit 3.0: identity against identity fires at equality
        configure(31'd65536, 1'b1, TraceLimReset, 16'd0);
        send_pose(ActEvaluate, pose_beat('0, '0, '0, turn_matrix(0)));

        // 1 m translation, 60 degree rotation (limit 2.0)
        configure(31'd65536, 1'b1, 31'sd536870912, 16'd0);
        send_pose(ActCommit, pose_beat('0, '0, '0, turn_matrix(0)));
        // one axis just under, then exactly at, the threshold
        send_pose(ActEvaluate, pose_beat(32'd65535, '0, '0, turn_matrix(0)));
        send_pose(ActEvaluate, pose_beat(32'd65536, '0, '0, turn_matrix(0)));
        // sum of squares just under and just over, no axis alone reaching it
        send_pose(ActEvaluate, pose_beat(32'd37837, 32'd37837, 32'd37837, turn_matrix(0)));
        send_pose(ActEvaluate, pose_beat(32'd37838, 32'd37838, 32'd37838, turn_matrix(0)));
        // quarter turn: trace 1.0 is below the limit
        send_pose(ActEvaluate, pose_beat('0, '0, '0, turn_matrix(1)));
        // most negative position and rotation elements
        send_pose(ActEvaluate, pose_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         {RotN{16'h8000}}));
        // non-orthonormal stored pose at the far corner, then the opposite corner
        send_pose(ActCommit, pose_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       {RotN{16'h8000}}));
        send_pose(ActEvaluate, pose_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         {RotN{16'h7FFF}}));
        send_pose(ActEvaluate, pose_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         {RotN{16'h8000}}));

        // largest threshold, rotation off, lowest limit, two-scan limit
        configure(31'h7FFF_FFFF, 1'b0, -31'sd805306368, 16'd2);
        send_pose(ActCommit, pose_beat(32'h8000_0000, '0, '0, turn_matrix(2)));
        send_pose(ActEvaluate, pose_beat(32'h8000_0000, '0, '0, turn_matrix(2)));
        send_pose(ActEvaluate, pose_beat(32'h8000_0000, '0, '0, turn_matrix(3)));
        send_pose(ActEvaluate, pose_beat(32'h7FFF_FFFF, '0, '0, turn_matrix(2)));

        // ---- long evaluate run: only the scan limit is live, crossed midway ----
        configure(31'd0, 1'b0, TraceLimReset, 16'd64);
        send_pose(ActCommit, pose_beat('0, '0, '0, turn_matrix(0)));
        repeat (ScanRun) send_random_pose(1'b1);

        // ---- random phases: sender idles lightly, then the receiver, then neither ----
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(31'd1 << 20, 1'b1, 31'($urandom_range(1610612736)) - 31'sd805306368,
                             16'd8);
                1: configure(31'h7FFF_FFFF, 1'b1, -31'sd805306368, 16'hFFFF);
                2: configure(31'd0, 1'b0, TraceLimReset, 16'd1);
                3: configure(31'($urandom_range(1 << 24, 1)), 1'b1, 31'sd0,
                             16'($urandom_range(20, 1)));
                4: configure(31'd1, 1'b1, TraceLimReset, 16'd0);
                default: configure(31'($urandom_range(32'h7FFF_FFFF)), 1'($urandom_range(1)),
                                   31'($urandom_range(1610612736)) - 31'sd805306368,
                                   16'($urandom_range(65535)));
            endcase
            send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 83 : 0;
            recv_idle_pct = (phase < 2) ? 83 : (phase < 4) ? 10 : 0;
            repeat (PhaseItems) send_random_pose(1'b0);
        end

        // drain, then give the pipeline a few more cycles to show any stray beat
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (decisions_pending != 0)
            @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);

        if (mismatch_count == 0 && decisions_pending == 0)
            $display("pose_keyframe_trigger_unit test passed");
        else
            $display("pose_keyframe_trigger_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pkt_pkg.sv
hw/rtl/pkt_cfg.sv
hw/rtl/pkt_front.sv
hw/rtl/pkt_eval.sv
hw/rtl/pose_keyframe_trigger_unit.sv
bench/keyframe_decision_checker.sv
bench/tb.sv
